[rtl/rgb565_frame_delta_encoder_unit_macros.svh]
// ---------------------------------------------------------------------------
// RGB565 frame delta encoder assertion macros
// Shared concurrent assertion shorthands for the encoder RTL.
// ---------------------------------------------------------------------------
`ifndef RGB565_FRAME_DELTA_ENCODER_UNIT_MACROS_SVH
`define RGB565_FRAME_DELTA_ENCODER_UNIT_MACROS_SVH

// A property that must hold in the same cycle, ignored while reset is high.
`define RGBFDE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define RGBFDE_ASSERT_STEP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rgbfde_pkg.sv]
// ---------------------------------------------------------------------------
// RGB565 frame delta encoder package
// Fixed field widths, register indexes, result kinds and the result type.
// ---------------------------------------------------------------------------
package rgbfde_pkg;

   // Field widths fixed by the interface.
   localparam int COLOR_W = 8;
   localparam int PIX_W   = 16;
   localparam int POS_W   = 9;
   localparam int BYTES_W = 22;
   localparam int CNT_W   = 19;
   localparam int SIZE_W  = 10;
   localparam int CSR_IDX_W = 2;

   // Saturation value of the per-frame change counter.
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MODE    = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 10'd512;
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 10'd512;

   // Result kinds.
   localparam logic KIND_RECORD  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // One result as it leaves the block.
   typedef struct packed {
      logic               kind;
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic [PIX_W-1:0]   pixel_value;
      logic [BYTES_W-1:0] delta_bytes;
      logic               last;
   } result_type;

endpackage

[rtl/rgbfde_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module rgbfde_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read; the read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rgbfde_pos.sv]
// ---------------------------------------------------------------------------
// RGB565 frame delta encoder raster position
// Row and column counters, frame store address and end-of-frame flag.
// ---------------------------------------------------------------------------
`include "rgb565_frame_delta_encoder_unit_macros.svh"

module rgbfde_pos #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        advance,
   input  logic [rgbfde_pkg::SIZE_W-1:0]               frame_width,
   input  logic [rgbfde_pkg::SIZE_W-1:0]               frame_height,
   output logic [$clog2(MAX_HEIGHT)-1:0]               row,
   output logic [$clog2(MAX_WIDTH)-1:0]                col,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     addr,
   output logic                                        end_of_frame
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);
   localparam int WSW = (CW + 1 > rgbfde_pkg::SIZE_W) ? CW + 1 : rgbfde_pkg::SIZE_W;
   localparam int HSW = (RW + 1 > rgbfde_pkg::SIZE_W) ? RW + 1 : rgbfde_pkg::SIZE_W;

   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [WSW-1:0] width_cfg, width_eff, width_last;
   logic [HSW-1:0] height_cfg, height_eff, height_last;
   logic           col_at_end, row_at_end;

   // Clamp the configured frame size into 1..MAX.
   always_comb begin
      width_cfg  = WSW'(frame_width);
      height_cfg = HSW'(frame_height);
      if (width_cfg == '0) begin
         width_eff = WSW'(1);
      end else if (width_cfg > WSW'(MAX_WIDTH)) begin
         width_eff = WSW'(MAX_WIDTH);
      end else begin
         width_eff = width_cfg;
      end
      if (height_cfg == '0) begin
         height_eff = HSW'(1);
      end else if (height_cfg > HSW'(MAX_HEIGHT)) begin
         height_eff = HSW'(MAX_HEIGHT);
      end else begin
         height_eff = height_cfg;
      end
      width_last  = width_eff - WSW'(1);
      height_last = height_eff - HSW'(1);
   end

   // A counter at or past the last position wraps, so a shrunk size wraps at once.
   assign col_at_end = WSW'(col_ff) >= width_last;
   assign row_at_end = HSW'(row_ff) >= height_last;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (col_at_end) begin
            col_in = '0;
            if (row_at_end) begin
               row_in = '0;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Frame store address is row-major with a fixed pitch of MAX_WIDTH.
   assign addr         = AW'(row_ff) * AW'(MAX_WIDTH) + AW'(col_ff);
   assign row          = row_ff;
   assign col          = col_ff;
   assign end_of_frame = col_at_end && row_at_end;

   `RGBFDE_ASSERT(a_col_range, clock, reset, (32'(col_ff) < MAX_WIDTH), "column out of range")
   `RGBFDE_ASSERT_STEP(a_frame_wrap, clock, reset, advance && col_at_end && row_at_end, (row_ff == '0) && (col_ff == '0), "frame did not wrap")

endmodule

[rtl/rgbfde_out.sv]
// ---------------------------------------------------------------------------
// RGB565 frame delta encoder result buffer
// Holds the pixel record and the summary of one pixel and hands them out in order.
// ---------------------------------------------------------------------------
`include "rgb565_frame_delta_encoder_unit_macros.svh"

module rgbfde_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   load_rec,
   input  logic                   load_sum,
   input  rgbfde_pkg::result_type rec_data,
   input  rgbfde_pkg::result_type sum_data,
   output logic                   can_load,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rgbfde_pkg::result_type rsp_data
);

   logic                   rec_vld_ff, rec_vld_in;
   logic                   sum_vld_ff, sum_vld_in;
   rgbfde_pkg::result_type rec_ff;
   rgbfde_pkg::result_type sum_ff;
   logic                   take;

   // The record goes out before the summary.
   assign rsp_valid = rec_vld_ff || sum_vld_ff;
   assign rsp_data  = rec_vld_ff ? rec_ff : sum_ff;
   assign take      = rsp_valid && !rsp_stall;

   // Room for new results once the buffer is empty or its last result leaves.
   assign can_load = (!rec_vld_ff && !sum_vld_ff) || (take && (rec_vld_ff ^ sum_vld_ff));

   always_comb begin
      rec_vld_in = rec_vld_ff;
      sum_vld_in = sum_vld_ff;
      if (take) begin
         if (rec_vld_ff) begin
            rec_vld_in = 1'b0;
         end else begin
            sum_vld_in = 1'b0;
         end
      end
      if (load) begin
         rec_vld_in = load_rec;
         sum_vld_in = load_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_vld_ff <= 1'b0;
         sum_vld_ff <= 1'b0;
      end else begin
         rec_vld_ff <= rec_vld_in;
         sum_vld_ff <= sum_vld_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= rec_data;
         sum_ff <= sum_data;
      end
   end

   `RGBFDE_ASSERT(a_load_room, clock, reset, (load |-> can_load), "results loaded over pending ones")

endmodule

[rtl/rgb565_frame_delta_encoder_unit.sv]
// ---------------------------------------------------------------------------
// RGB565 frame delta encoder
// Converts RGB888 raster pixels to RGB565 and emits every pixel (full mode)
// or only pixels that differ from a stored reference frame (delta mode),
// followed by a byte-count summary at the end of each delta frame.
// ---------------------------------------------------------------------------
//
//   Channel  Ports    Handshake      Moves
//   ------   ------   ------------   ---------------------------------------
//   input    req_*    valid / stall  one RGB888 pixel request
//   result   rsp_*    valid / stall  one pixel record or frame summary
//   config   csr_*    valid / ready  register index and write data
//
// A pixel is accepted every cycle unless stalled; results leave via rgbfde_out.
// The frame store read is issued at acceptance and compared in the next stage.
// A pixel with both a record and a summary sends the record, then the summary.
// Reset clears the counters and control state; the frame store needs no
// clearing pass, and a rsp_stall stalls the request side when the buffer is full.
//
`include "rgb565_frame_delta_encoder_unit_macros.svh"

module rgb565_frame_delta_encoder_unit #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Pixel requests
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rgbfde_pkg::COLOR_W-1:0]       req_red,
   input  logic [rgbfde_pkg::COLOR_W-1:0]       req_green,
   input  logic [rgbfde_pkg::COLOR_W-1:0]       req_blue,
   // Results
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_kind,
   output logic [rgbfde_pkg::POS_W-1:0]         rsp_row,
   output logic [rgbfde_pkg::POS_W-1:0]         rsp_col,
   output logic [rgbfde_pkg::PIX_W-1:0]         rsp_pixel_value,
   output logic [rgbfde_pkg::BYTES_W-1:0]       rsp_delta_bytes,
   output logic                                 rsp_last,
   // Configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rgbfde_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rgbfde_pkg::SIZE_W-1:0]        csr_data
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   // Configuration registers
   logic [rgbfde_pkg::SIZE_W-1:0] frame_width_ff, frame_height_ff;
   logic                          full_mode_ff;

   // Position stage
   logic [RW-1:0] pos_row;
   logic [CW-1:0] pos_col;
   logic [AW-1:0] pos_addr;
   logic          pos_eof;
   logic          accept;
   logic [rgbfde_pkg::PIX_W-1:0] req_pix;

   // Compare stage
   logic                          s1_vld_ff, s1_vld_in;
   logic [rgbfde_pkg::PIX_W-1:0]  s1_pix_ff;
   logic [rgbfde_pkg::POS_W-1:0]  s1_row_ff, s1_col_ff;
   logic [AW-1:0]                 s1_addr_ff;
   logic                          s1_delta_ff, s1_eof_ff;
   logic                          s1_fwd_ff;
   logic [rgbfde_pkg::PIX_W-1:0]  s1_fwd_pix_ff;
   logic [rgbfde_pkg::PIX_W-1:0]  ram_rd_data, stored_pix;
   logic                          changed, has_rec, has_sum, advance;

   // Change counter
   logic [rgbfde_pkg::CNT_W-1:0]  cnt_ff, cnt_in, cnt_upd;

   // Result buffer
   logic                          can_load;
   rgbfde_pkg::result_type        rec_data, sum_data, rsp_data;

   // Configuration port always takes a write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= rgbfde_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= rgbfde_pkg::FRAME_HEIGHT_RST;
         full_mode_ff    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rgbfde_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            rgbfde_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            rgbfde_pkg::CSR_FULL_MODE:    full_mode_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Request acceptance stalls only while the compare stage cannot move on.
   assign req_stall = s1_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign req_pix   = {req_red[7:3], req_green[7:2], req_blue[7:3]};

   rgbfde_pos #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_pos (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .row          (pos_row),
      .col          (pos_col),
      .addr         (pos_addr),
      .end_of_frame (pos_eof)
   );

   // Reference frame store: read at acceptance, written when the pixel leaves compare.
   rgbfde_ram #(
      .WIDTH (rgbfde_pkg::PIX_W),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (pos_addr),
      .rd_data (ram_rd_data)
   );

   // Compare stage control.
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (advance) begin
         s1_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   // Compare stage payload; a write to the same entry in the read cycle is forwarded.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff     <= req_pix;
         s1_row_ff     <= rgbfde_pkg::POS_W'(pos_row);
         s1_col_ff     <= rgbfde_pkg::POS_W'(pos_col);
         s1_addr_ff    <= pos_addr;
         s1_delta_ff   <= !full_mode_ff;
         s1_eof_ff     <= pos_eof;
         s1_fwd_ff     <= advance && (s1_addr_ff == pos_addr);
         s1_fwd_pix_ff <= s1_pix_ff;
      end
   end

   // Compare against the stored pixel and decide which results this pixel makes.
   assign stored_pix = s1_fwd_ff ? s1_fwd_pix_ff : ram_rd_data;
   assign changed    = stored_pix != s1_pix_ff;
   assign has_rec    = !s1_delta_ff || changed;
   assign has_sum    = s1_delta_ff && s1_eof_ff;
   assign advance    = s1_vld_ff && (can_load || !(has_rec || has_sum));

   // Per-frame change count, saturating, cleared at every frame end.
   always_comb begin
      cnt_upd = cnt_ff;
      if (s1_delta_ff && changed && (cnt_ff != rgbfde_pkg::CNT_MAX)) begin
         cnt_upd = cnt_ff + rgbfde_pkg::CNT_W'(1);
      end
      cnt_in = cnt_ff;
      if (advance) begin
         cnt_in = s1_eof_ff ? '0 : cnt_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Result contents.
   always_comb begin
      rec_data.kind        = rgbfde_pkg::KIND_RECORD;
      rec_data.row         = s1_row_ff;
      rec_data.col         = s1_col_ff;
      rec_data.pixel_value = s1_pix_ff;
      rec_data.delta_bytes = '0;
      rec_data.last        = !has_sum;
      sum_data.kind        = rgbfde_pkg::KIND_SUMMARY;
      sum_data.row         = '0;
      sum_data.col         = '0;
      sum_data.pixel_value = '0;
      sum_data.delta_bytes = {cnt_upd, 3'b000};
      sum_data.last        = 1'b1;
   end

   rgbfde_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && (has_rec || has_sum)),
      .load_rec  (has_rec),
      .load_sum  (has_sum),
      .rec_data  (rec_data),
      .sum_data  (sum_data),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind        = rsp_data.kind;
   assign rsp_row         = rsp_data.row;
   assign rsp_col         = rsp_data.col;
   assign rsp_pixel_value = rsp_data.pixel_value;
   assign rsp_delta_bytes = rsp_data.delta_bytes;
   assign rsp_last        = rsp_data.last;

   `RGBFDE_ASSERT(a_stall_cause, clock, reset, (req_stall |-> s1_vld_ff), "request stalled with empty compare stage")
   `RGBFDE_ASSERT_STEP(a_count_clear, clock, reset, advance && s1_eof_ff, cnt_ff == '0, "change count not cleared at frame end")
   `RGBFDE_ASSERT(a_full_no_sum, clock, reset, ((s1_vld_ff && !s1_delta_ff) |-> !has_sum), "summary made in full mode")

endmodule
